// ----- rtl/gbd_pkg.sv -----
// Shared types, constants and register codes for the grid box decoder.
// No dependencies; used by gbd_exp_unit and grid_box_decoder.
package gbd_pkg;

    localparam int GRID_DIM_DEF  = 1024;
    localparam int EXP_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_STRIDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGRESSION_MODE = 3'd4;

    localparam logic [1:0] CMP_PLAIN    = 2'd0;
    localparam logic [1:0] CMP_SUPPRESS = 2'd1;
    localparam logic [1:0] CMP_STITCH   = 2'd2;

    localparam logic [1:0] RGR_NONE   = 2'd0;
    localparam logic [1:0] RGR_LINEAR = 2'd1;
    localparam logic [1:0] RGR_EXP    = 2'd2;

    localparam logic [6:0]  RST_GRID_STRIDE     = 7'd2;
    localparam logic [15:0] RST_FIELD_SIZE      = 16'd192;
    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd39322;

    localparam logic signed [31:0] LOG2E_Q14 = 32'sd23637;
    localparam logic [63:0]        LN2_Q30   = 64'd744261118;
    localparam logic [63:0]        ONE_Q30   = 64'd1 << 30;

    typedef struct packed {
        logic        [9:0]  cell_x;
        logic        [9:0]  cell_y;
        logic        [15:0] score;
        logic        [15:0] pooled_score;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic        [15:0] stitch_field;
        logic signed [15:0] reg_a;
        logic signed [15:0] reg_b;
        logic signed [15:0] reg_c;
        logic signed [15:0] reg_d;
    } t_cell_in;

    typedef struct packed {
        logic               kept;
        logic signed [31:0] box_left;
        logic signed [31:0] box_top;
        logic signed [31:0] box_width;
        logic signed [31:0] box_height;
        logic        [15:0] box_score;
    } t_box_out;

endpackage

// ----- rtl/gbd_exp_unit.sv -----
// Exponential size unit: size = round(f * 2^(r*log2e)) via a 2^x table.
// Four register stages; depends on gbd_pkg.
module gbd_exp_unit #(
    parameter int EXP_TABLE_DEPTH = gbd_pkg::EXP_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic signed [15:0] i_reg,
    input  logic        [15:0] i_field,
    output logic        [31:0] o_size
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int DEP_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FP_W  = 26 + DEP_W;

    typedef logic [30:0] t_tab [EXP_TABLE_DEPTH];

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            z    = 64'(i) * gbd_pkg::LN2_Q30 / 64'(EXP_TABLE_DEPTH);
            sum  = gbd_pkg::ONE_Q30;
            term = gbd_pkg::ONE_Q30;
            term = mul_q30(term, z) / 64'd1;  sum = sum + term;
            term = mul_q30(term, z) / 64'd2;  sum = sum + term;
            term = mul_q30(term, z) / 64'd3;  sum = sum + term;
            term = mul_q30(term, z) / 64'd4;  sum = sum + term;
            term = mul_q30(term, z) / 64'd5;  sum = sum + term;
            term = mul_q30(term, z) / 64'd6;  sum = sum + term;
            term = mul_q30(term, z) / 64'd7;  sum = sum + term;
            term = mul_q30(term, z) / 64'd8;  sum = sum + term;
            term = mul_q30(term, z) / 64'd9;  sum = sum + term;
            term = mul_q30(term, z) / 64'd10; sum = sum + term;
            term = mul_q30(term, z) / 64'd11; sum = sum + term;
            term = mul_q30(term, z) / 64'd12; sum = sum + term;
            term = mul_q30(term, z) / 64'd13; sum = sum + term;
            term = mul_q30(term, z) / 64'd14; sum = sum + term;
            term = mul_q30(term, z) / 64'd15; sum = sum + term;
            term = mul_q30(term, z) / 64'd16; sum = sum + term;
            term = mul_q30(term, z) / 64'd17; sum = sum + term;
            term = mul_q30(term, z) / 64'd18; sum = sum + term;
            term = mul_q30(term, z) / 64'd19; sum = sum + term;
            term = mul_q30(term, z) / 64'd20; sum = sum + term;
            tab[i] = sum[30:0];
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = build_tab();

    logic signed [31:0] n_w;
    logic [FP_W-1:0]    n_fidx;
    logic [47:0]        n_round;

    logic [30:0]      r_w;
    logic [15:0]      r_f2;
    logic [IDX_W-1:0] r_idx;
    logic [5:0]       r_s3;
    logic [15:0]      r_f3;
    logic [30:0]      r_tab;
    logic [5:0]       r_s4;
    logic [15:0]      r_f4;
    logic [46:0]      r_prod;
    logic [5:0]       r_s5;

    always_comb begin
        n_w    = 32'(i_reg) * gbd_pkg::LOG2E_Q14 + 32'sd1073741824;
        n_fidx = FP_W'(r_w[25:0]) * FP_W'(EXP_TABLE_DEPTH);
        n_round = {1'b0, r_prod} + (48'd1 << (r_s5 - 6'd1));
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w[30:0];
        r_f2   <= i_field;
        r_idx  <= n_fidx[26 +: IDX_W];
        r_s3   <= 6'd46 - {1'b0, r_w[30:26]};
        r_f3   <= r_f2;
        r_tab  <= EXP_TAB[r_idx];
        r_s4   <= r_s3;
        r_f4   <= r_f3;
        r_prod <= 47'(r_f4) * 47'(r_tab);
        r_s5   <= r_s4;
    end

    assign o_size = 32'(n_round >> r_s5);

endmodule

// ----- rtl/grid_box_decoder.sv -----
// Grid box decoder top level: one detection-map cell in, one box out.
// One cell per cycle, busy is never raised. Each cell passes through the six-stage datapath
// (select, offset, multiply, round, divide-by-three, assemble) to a registered o_done beat.
// Synchronous active-low reset clears the valid pipe and loads the register defaults.
// Results cannot be stalled. Depends on gbd_pkg and gbd_exp_unit.
module grid_box_decoder #(
    parameter int GRID_DIM        = gbd_pkg::GRID_DIM_DEF,
    parameter int EXP_TABLE_DEPTH = gbd_pkg::EXP_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gbd_pkg::t_cell_in                i_cell,
    output logic                             o_done,
    output gbd_pkg::t_box_out                o_box,
    input  logic                             i_cfg_we,
    input  logic [gbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    function automatic logic [9:0] grid_mod(input logic [9:0] v);
        logic [17:0] rem;
        rem = 18'(v);
        for (int k = 5; k >= 0; k--) begin
            if (rem >= 18'(GRID_DIM << k)) begin
                rem = rem - 18'(GRID_DIM << k);
            end
        end
        return rem[9:0];
    endfunction

    function automatic logic signed [21:0] round4096(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [33:0] sum;
        logic [21:0] q;
        mag = v[33] ? 34'(-v) : 34'(v);
        sum = mag + 34'd2048;
        q   = {1'b0, sum[32:12]};
        return v[33] ? $signed(-q) : $signed(q);
    endfunction

    // configuration
    logic [6:0]  r_grid_stride;
    logic [15:0] r_field_size;
    logic [15:0] r_score_threshold;
    logic [1:0]  r_compare_mode;
    logic [1:0]  r_regression_mode;

    // valid pipe
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_done;

    // stage 1
    logic               n_keep;
    logic [15:0]        n_f;
    logic signed [15:0] n_bx, n_by;
    logic               r1_keep;
    logic [15:0]        r1_f;
    logic signed [15:0] r1_bx, r1_by;
    logic [9:0]         r1_cx, r1_cy;
    logic signed [15:0] r1_ra, r1_rb, r1_rc, r1_rd;
    logic [15:0]        r1_score;

    // stage 2
    logic [16:0]        n_sx, n_sy;
    logic signed [16:0] n_rl, n_rt, n_rw, n_rh;
    logic               n_exp;
    logic               r2_keep, r2_exp;
    logic [15:0]        r2_f;
    logic signed [22:0] r2_px, r2_py;
    logic signed [16:0] r2_rl, r2_rt, r2_rw, r2_rh;
    logic [15:0]        r2_score;

    // stage 3
    logic               r3_keep, r3_exp;
    logic [15:0]        r3_f;
    logic signed [38:0] r3_mx, r3_my;
    logic signed [33:0] r3_ml, r3_mt, r3_mw, r3_mh;
    logic [15:0]        r3_score;

    // stage 4
    logic [38:0]        n_ax, n_ay;
    logic               r4_keep, r4_exp;
    logic [15:0]        r4_f;
    logic [31:0]        r4_ux, r4_uy;
    logic               r4_nx, r4_ny;
    logic signed [21:0] r4_dl, r4_dt, r4_dw, r4_dh;
    logic [15:0]        r4_score;

    // stage 5
    logic [63:0]        n_qx, n_qy;
    logic               r5_keep, r5_exp;
    logic [29:0]        r5_qx, r5_qy;
    logic               r5_nx, r5_ny;
    logic signed [21:0] r5_dl, r5_dt;
    logic signed [22:0] r5_lw, r5_lh;
    logic [15:0]        r5_score;

    // stage 6
    logic [31:0]        w_exp_w, w_exp_h;
    logic signed [31:0] n_sx32, n_sy32;
    gbd_pkg::t_box_out  n_box;
    gbd_pkg::t_box_out  r_box;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_stride     <= gbd_pkg::RST_GRID_STRIDE;
            r_field_size      <= gbd_pkg::RST_FIELD_SIZE;
            r_score_threshold <= gbd_pkg::RST_SCORE_THRESHOLD;
            r_compare_mode    <= gbd_pkg::CMP_PLAIN;
            r_regression_mode <= gbd_pkg::RGR_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbd_pkg::REG_GRID_STRIDE:     r_grid_stride     <= i_cfg_data[6:0];
                gbd_pkg::REG_FIELD_SIZE:      r_field_size      <= i_cfg_data;
                gbd_pkg::REG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data;
                gbd_pkg::REG_COMPARE_MODE:    r_compare_mode    <= i_cfg_data[1:0];
                gbd_pkg::REG_REGRESSION_MODE: r_regression_mode <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r_done   <= r5_valid;
        end
    end

    // stage 1: keep decision and field select
    always_comb begin
        n_keep = i_cell.score > r_score_threshold;
        n_f    = r_field_size;
        n_bx   = 16'sd0;
        n_by   = 16'sd0;
        if (r_compare_mode == gbd_pkg::CMP_SUPPRESS && i_cell.score < i_cell.pooled_score) begin
            n_keep = 1'b0;
        end
        if (r_compare_mode == gbd_pkg::CMP_STITCH) begin
            n_f  = i_cell.stitch_field;
            n_bx = i_cell.shift_x;
            n_by = i_cell.shift_y;
            if (i_cell.stitch_field == 16'd0) begin
                n_keep = 1'b0;
            end
        end
    end

    // stage 2: grid position and regression offsets
    always_comb begin
        n_sx = 17'(r1_cx) * 17'(r_grid_stride);
        n_sy = 17'(r1_cy) * 17'(r_grid_stride);
        n_rl = 17'sd0;
        n_rt = 17'sd0;
        n_rw = 17'sd0;
        n_rh = 17'sd0;
        n_exp = 1'b0;
        unique case (r_regression_mode)
            gbd_pkg::RGR_LINEAR: begin
                n_rl = 17'(r1_rb);
                n_rt = 17'(r1_ra);
                n_rw = 17'(r1_rd) - 17'(r1_rb);
                n_rh = 17'(r1_rc) - 17'(r1_ra);
            end
            gbd_pkg::RGR_EXP: begin
                n_rl  = 17'(r1_ra);
                n_rt  = 17'(r1_rb);
                n_exp = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // stage 4: magnitudes for rounded divides
    always_comb begin
        n_ax = r3_mx[38] ? 39'(-r3_mx) : 39'(r3_mx);
        n_ay = r3_my[38] ? 39'(-r3_my) : 39'(r3_my);
    end

    // stage 5: divide by three through the reciprocal
    always_comb begin
        n_qx = 64'(r4_ux) * 64'(32'hAAAA_AAAB);
        n_qy = 64'(r4_uy) * 64'(32'hAAAA_AAAB);
    end

    // stage 6: assemble the box
    always_comb begin
        n_sx32 = r5_nx ? -$signed({2'b00, r5_qx}) : $signed({2'b00, r5_qx});
        n_sy32 = r5_ny ? -$signed({2'b00, r5_qy}) : $signed({2'b00, r5_qy});
        n_box  = '0;
        if (r5_keep) begin
            n_box.kept       = 1'b1;
            n_box.box_left   = n_sx32 + 32'(r5_dl);
            n_box.box_top    = n_sy32 + 32'(r5_dt);
            n_box.box_width  = r5_exp ? $signed(w_exp_w) : 32'(r5_lw);
            n_box.box_height = r5_exp ? $signed(w_exp_h) : 32'(r5_lh);
            n_box.box_score  = r5_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_keep  <= n_keep;
        r1_f     <= n_f;
        r1_bx    <= n_bx;
        r1_by    <= n_by;
        r1_cx    <= grid_mod(i_cell.cell_x);
        r1_cy    <= grid_mod(i_cell.cell_y);
        r1_ra    <= i_cell.reg_a;
        r1_rb    <= i_cell.reg_b;
        r1_rc    <= i_cell.reg_c;
        r1_rd    <= i_cell.reg_d;
        r1_score <= i_cell.score;

        r2_keep  <= r1_keep;
        r2_exp   <= n_exp;
        r2_f     <= r1_f;
        r2_px    <= $signed({2'b00, n_sx, 4'h0}) - 23'(r1_bx);
        r2_py    <= $signed({2'b00, n_sy, 4'h0}) - 23'(r1_by);
        r2_rl    <= n_rl;
        r2_rt    <= n_rt;
        r2_rw    <= n_rw;
        r2_rh    <= n_rh;
        r2_score <= r1_score;

        r3_keep  <= r2_keep;
        r3_exp   <= r2_exp;
        r3_f     <= r2_f;
        r3_mx    <= 39'(r2_px) * $signed({23'd0, r2_f});
        r3_my    <= 39'(r2_py) * $signed({23'd0, r2_f});
        r3_ml    <= 34'(r2_rl) * $signed({18'd0, r2_f});
        r3_mt    <= 34'(r2_rt) * $signed({18'd0, r2_f});
        r3_mw    <= 34'(r2_rw) * $signed({18'd0, r2_f});
        r3_mh    <= 34'(r2_rh) * $signed({18'd0, r2_f});
        r3_score <= r2_score;

        r4_keep  <= r3_keep;
        r4_exp   <= r3_exp;
        r4_f     <= r3_f;
        r4_ux    <= 32'((n_ax + 39'd96) >> 6);
        r4_uy    <= 32'((n_ay + 39'd96) >> 6);
        r4_nx    <= r3_mx[38];
        r4_ny    <= r3_my[38];
        r4_dl    <= round4096(r3_ml);
        r4_dt    <= round4096(r3_mt);
        r4_dw    <= round4096(r3_mw);
        r4_dh    <= round4096(r3_mh);
        r4_score <= r3_score;

        r5_keep  <= r4_keep;
        r5_exp   <= r4_exp;
        r5_qx    <= n_qx[62:33];
        r5_qy    <= n_qy[62:33];
        r5_nx    <= r4_nx;
        r5_ny    <= r4_ny;
        r5_dl    <= r4_dl;
        r5_dt    <= r4_dt;
        r5_lw    <= $signed({7'd0, r4_f}) + 23'(r4_dw);
        r5_lh    <= $signed({7'd0, r4_f}) + 23'(r4_dh);
        r5_score <= r4_score;

        r_box    <= n_box;
    end

    gbd_exp_unit #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_exp_w (
        .i_clk   (i_clk),
        .i_reg   (r1_rc),
        .i_field (r1_f),
        .o_size  (w_exp_w)
    );

    gbd_exp_unit #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_exp_h (
        .i_clk   (i_clk),
        .i_reg   (r1_rd),
        .i_field (r1_f),
        .o_size  (w_exp_h)
    );

    assign o_done = r_done;
    assign o_box  = r_box;

endmodule

// ----- verif/tb_grid_box_decoder.sv -----
// Testbench for grid_box_decoder: drives cells with random gaps and register settings,
// checks each box against a built-in model or a given box. Depends on gbd_pkg and the RTL.
module tb_grid_box_decoder;
    import gbd_pkg::*;

    localparam int EXP_DEPTH     = EXP_DEPTH_DEF;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_CELLS   = 115;
    localparam logic [1:0] CMP_UNUSED = 2'd3;
    localparam logic [1:0] RGR_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0]  stride;
        logic [15:0] field;
        logic [15:0] thr;
        logic [1:0]  cmp;
        logic [1:0]  rgr;
    } t_regs;

    typedef struct {
        t_regs    regs;
        t_cell_in stim;
        bit       typed;
        t_box_out box;
    } t_row;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_cell_in i_cell = '0;
    logic     o_done;
    t_box_out o_box;
    logic     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    longint unsigned pow2_frac [EXP_DEPTH];
    t_regs    cur_regs;
    t_box_out staged_boxes [$];
    t_box_out expected_boxes [$];
    t_row     plan [$];
    int       errors = 0;
    int       kept_count = 0;
    int       dropped_count = 0;
    int       settings_count = 0;
    int       idle_cycles = 0;

    grid_box_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cell     (i_cell),
        .o_done     (o_done),
        .o_box      (o_box),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint rnd_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint exp_extent(longint f, longint r);
        longint          w;
        longint          k;
        longint unsigned wb;
        longint unsigned frac;
        longint unsigned idx;
        longint unsigned prod;
        int              s;
        w    = r * longint'(LOG2E_Q14) + (longint'(1) << 30);
        wb   = w;
        k    = longint'(wb >> 26) - 16;
        frac = wb & 64'h3FF_FFFF;
        idx  = (frac * EXP_DEPTH) >> 26;
        if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
        prod = longint'(f) * pow2_frac[idx];
        s    = 30 - int'(k);
        return longint'((prod + (64'd1 << (s - 1))) >> s);
    endfunction

    function automatic t_box_out decode_box(t_cell_in c);
        longint   cx;
        longint   cy;
        longint   f;
        longint   bx;
        longint   by;
        longint   ra;
        longint   rb;
        longint   rc;
        longint   rd;
        longint   stride;
        longint   left;
        longint   top;
        longint   wid;
        longint   hei;
        bit       keep;
        t_box_out b;
        cx     = c.cell_x % GRID_DIM_DEF;
        cy     = c.cell_y % GRID_DIM_DEF;
        stride = cur_regs.stride;
        f      = cur_regs.field;
        bx     = 0;
        by     = 0;
        ra     = longint'($signed(c.reg_a));
        rb     = longint'($signed(c.reg_b));
        rc     = longint'($signed(c.reg_c));
        rd     = longint'($signed(c.reg_d));
        keep   = c.score > cur_regs.thr;
        if (cur_regs.cmp == CMP_SUPPRESS && c.score < c.pooled_score) keep = 1'b0;
        if (cur_regs.cmp == CMP_STITCH) begin
            f  = c.stitch_field;
            bx = longint'($signed(c.shift_x));
            by = longint'($signed(c.shift_y));
            if (f == 0) keep = 1'b0;
        end
        b = '0;
        if (!keep) return b;
        left = rnd_div((cx * stride * 16 - bx) * f, 192);
        top  = rnd_div((cy * stride * 16 - by) * f, 192);
        wid  = f;
        hei  = f;
        case (cur_regs.rgr)
            RGR_LINEAR: begin
                left += rnd_div(rb * f, 4096);
                top  += rnd_div(ra * f, 4096);
                wid  += rnd_div((rd - rb) * f, 4096);
                hei  += rnd_div((rc - ra) * f, 4096);
            end
            RGR_EXP: begin
                left += rnd_div(ra * f, 4096);
                top  += rnd_div(rb * f, 4096);
                wid  = exp_extent(f, rc);
                hei  = exp_extent(f, rd);
            end
            default: ;
        endcase
        b.kept       = 1'b1;
        b.box_left   = clamp32(left);
        b.box_top    = clamp32(top);
        b.box_width  = clamp32(wid);
        b.box_height = clamp32(hei);
        b.box_score  = c.score;
        return b;
    endfunction

    function automatic t_regs mk_regs(int stride, int field, int thr, logic [1:0] cmp,
                                      logic [1:0] rgr);
        return '{stride[6:0], field[15:0], thr[15:0], cmp, rgr};
    endfunction

    function automatic void add_row(t_regs r, t_cell_in c, bit typed, t_box_out b);
        t_row row;
        row.regs  = r;
        row.stim  = c;
        row.typed = typed;
        row.box   = b;
        plan.push_back(row);
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_cell_in rand_cell();
        t_cell_in c;
        c.cell_x       = $urandom_range(0, 1023);
        c.cell_y       = $urandom_range(0, 1023);
        c.score        = $urandom_range(0, 65535);
        c.pooled_score = $urandom_range(0, 65535);
        c.shift_x      = $urandom_range(0, 65535);
        c.shift_y      = $urandom_range(0, 65535);
        c.stitch_field = $urandom_range(0, 65535);
        c.reg_a        = $urandom_range(0, 65535);
        c.reg_b        = $urandom_range(0, 65535);
        c.reg_c        = $urandom_range(0, 65535);
        c.reg_d        = $urandom_range(0, 65535);
        if ($urandom_range(0, 3) != 0 && cur_regs.thr != 16'hFFFF)
            c.score = $urandom_range(cur_regs.thr + 1, 65535);
        if ($urandom_range(0, 1) != 0)
            c.pooled_score = c.score + 16'($urandom_range(0, 2)) - 16'd1;
        if ($urandom_range(0, 7) == 0) c.stitch_field = '0;
        if ($urandom_range(0, 15) == 0) c.reg_c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 15) == 0) c.reg_d = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return c;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic drive_cell(t_cell_in c, bit typed, t_box_out b);
        staged_boxes.push_back(typed ? b : decode_box(c));
        start  <= 1'b1;
        i_cell <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (staged_boxes.size() + expected_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_regs(t_regs r);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_GRID_STRIDE;
        i_cfg_data <= CFG_DATA_W'(r.stride);
        @(posedge i_clk);
        i_cfg_idx  <= REG_FIELD_SIZE;
        i_cfg_data <= r.field;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SCORE_THRESHOLD;
        i_cfg_data <= r.thr;
        @(posedge i_clk);
        i_cfg_idx  <= REG_COMPARE_MODE;
        i_cfg_data <= CFG_DATA_W'(r.cmp);
        @(posedge i_clk);
        i_cfg_idx  <= REG_REGRESSION_MODE;
        i_cfg_data <= CFG_DATA_W'(r.rgr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_regs = r;
        settings_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_box_out want;
        bool_accept : begin end
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_boxes.size() == 0) begin
                    $error("box beat with no cell outstanding");
                    errors++;
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("kept", want.kept, o_box.kept);
                    check_field("box_left", want.box_left, o_box.box_left);
                    check_field("box_top", want.box_top, o_box.box_top);
                    check_field("box_width", want.box_width, o_box.box_width);
                    check_field("box_height", want.box_height, o_box.box_height);
                    check_field("box_score", want.box_score, o_box.box_score);
                    if (want.kept) kept_count++;
                    else dropped_count++;
                end
            end
            if (start && busy == 1'b0 && staged_boxes.size() != 0)
                expected_boxes.push_back(staged_boxes.pop_front());
        end
        if ((start && busy == 1'b0) || o_done === 1'b1) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $error("no beat for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : main
        longint unsigned z;
        longint unsigned term;
        longint unsigned sum;
        t_regs           r0;
        t_regs           r;
        bit              dense;
        t_box_out        zero_box;

        for (int i = 0; i < EXP_DEPTH; i++) begin
            z    = longint'(i) * LN2_Q30 / EXP_DEPTH;
            sum  = ONE_Q30;
            term = ONE_Q30;
            for (int n = 1; n <= 20; n++) begin
                term = ((term * z) >> 30) / longint'(n);
                sum += term;
            end
            pow2_frac[i] = sum[31:0];
        end
        r0       = mk_regs(RST_GRID_STRIDE, RST_FIELD_SIZE, RST_SCORE_THRESHOLD,
                           CMP_PLAIN, RGR_NONE);
        cur_regs = r0;
        zero_box = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(r0, t_cell_in'{10'd0, 10'd0, 16'hFFFF, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                t_box_out'{1'b1, 32'sd0, 32'sd0, 32'sd192, 32'sd192, 16'hFFFF});
        add_row(r0, t_cell_in'{10'd9, 10'd3, 16'd39322, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd5, 16'sd6, 16'sd7, 16'sd8}, 1'b1, zero_box);
        add_row(r0, t_cell_in'{10'h3FF, 10'h3FF, 16'd0, 16'hFFFF, -16'sd1, -16'sd1, 16'hFFFF,
                -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, zero_box);
        add_row(r0, t_cell_in'{10'd1023, 10'd1023, 16'd40000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                t_box_out'{1'b1, 32'sd32736, 32'sd32736, 32'sd192, 32'sd192, 16'd40000});
        add_row(r0, t_cell_in'{10'd5, 10'd7, 16'd39323, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd100, -16'sd100, 16'sd0, 16'sd0}, 1'b0, zero_box);

        r = mk_regs(2, 192, 39322, CMP_SUPPRESS, RGR_NONE);
        add_row(r, t_cell_in'{10'd4, 10'd4, 16'd50000, 16'd50001, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_box);
        add_row(r, t_cell_in'{10'd4, 10'd4, 16'd50000, 16'd50000, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, zero_box);
        add_row(r, t_cell_in'{10'd17, 10'd900, 16'd50000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, zero_box);

        r = mk_regs(3, 192, 1000, CMP_STITCH, RGR_NONE);
        add_row(r, t_cell_in'{10'd8, 10'd8, 16'd60000, 16'd0, 16'sd64, 16'sd64, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_box);
        add_row(r, t_cell_in'{10'd1023, 10'd0, 16'd60000, 16'd0, 16'sh7FFF, 16'sh8000,
                16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, zero_box);
        add_row(r, t_cell_in'{10'd0, 10'd1023, 16'd60000, 16'd0, 16'sh8000, 16'sh7FFF,
                16'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, zero_box);

        r = mk_regs(2, 192, 1000, CMP_UNUSED, RGR_NONE);
        add_row(r, t_cell_in'{10'd33, 10'd44, 16'd2000, 16'd9000, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, zero_box);

        r = mk_regs(4, 256, 1000, CMP_PLAIN, RGR_LINEAR);
        add_row(r, t_cell_in'{10'd100, 10'd200, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0, zero_box);
        add_row(r, t_cell_in'{10'd100, 10'd200, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, 1'b0, zero_box);

        r = mk_regs(4, 256, 1000, CMP_PLAIN, RGR_EXP);
        add_row(r, t_cell_in'{10'd12, 10'd13, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0, zero_box);
        add_row(r, t_cell_in'{10'd12, 10'd13, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, zero_box);
        add_row(r, t_cell_in'{10'd12, 10'd13, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd4096}, 1'b0, zero_box);

        r = mk_regs(4, 256, 1000, CMP_PLAIN, RGR_UNUSED);
        add_row(r, t_cell_in'{10'd12, 10'd13, 16'd3000, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd1234, -16'sd4321, 16'sd2222, -16'sd3333}, 1'b0, zero_box);

        r = mk_regs(0, 0, 0, CMP_PLAIN, RGR_LINEAR);
        add_row(r, t_cell_in'{10'd500, 10'd600, 16'd1, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b1,
                t_box_out'{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd1});
        add_row(r, t_cell_in'{10'd500, 10'd600, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_box);

        r = mk_regs(127, 65535, 65534, CMP_STITCH, RGR_EXP);
        add_row(r, t_cell_in'{10'd1023, 10'd1023, 16'hFFFF, 16'd0, 16'sh8000, 16'sh8000,
                16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, zero_box);

        r = mk_regs(64, 65535, 65535, CMP_PLAIN, RGR_NONE);
        add_row(r, t_cell_in'{10'd1, 10'd1, 16'hFFFF, 16'd0, 16'sd0, 16'sd0, 16'd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_box);

        foreach (plan[i]) begin
            if (plan[i].regs != cur_regs) begin
                drain();
                apply_regs(plan[i].regs);
            end
            drive_cell(plan[i].stim, plan[i].typed, plan[i].box);
            pause(pick_gap());
        end

        for (int p = 0; p < 16; p++) begin
            drain();
            case ($urandom_range(0, 9))
                0:       r.stride = 7'd0;
                1:       r.stride = 7'd127;
                2:       r.stride = 7'd1;
                3:       r.stride = 7'd64;
                default: r.stride = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 7))
                0:       r.field = 16'd0;
                1:       r.field = 16'hFFFF;
                2:       r.field = 16'd1;
                default: r.field = $urandom_range(1, 65535);
            endcase
            case ($urandom_range(0, 7))
                0:       r.thr = 16'd0;
                1:       r.thr = 16'hFFFF;
                default: r.thr = $urandom_range(0, 65535);
            endcase
            r.cmp = 2'(p % 4);
            r.rgr = 2'(p / 4);
            apply_regs(r);
            dense = (p % 5 == 2);
            for (int n = 0; n < PHASE_CELLS; n++) begin
                drive_cell(rand_cell(), 1'b0, zero_box);
                if ($urandom_range(0, 149) == 0) drain();
                else pause(dense ? 0 : pick_gap());
            end
        end

        drain();
        $display("Decoded %0d cells: %0d boxes kept, %0d dropped,", kept_count + dropped_count,
                 kept_count, dropped_count);
        $display("across %0d register settings covering all compare and regression modes.",
                 settings_count + 1);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
